// File: rtl/core/srkt_pkg.sv
// ----------------------------------------------------------------------------
// srkt_pkg: shared definitions for the sorted reference-counted key table
// Widths, operation and status codes, controller states and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package srkt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int FUNC_W  = 2;
  localparam int KEY_W   = 16;
  localparam int HND_W   = 32;
  localparam int REF_W   = 16;
  localparam int STAT_W  = 3;
  localparam int USED_W  = 9;
  localparam int ENTRY_W = KEY_W + HND_W + REF_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_LOOKUP = 2'd2,
    FN_NONE   = 2'd3
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_RAISED    = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FOUND     = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_INS_RD,
    S_INS_WR,
    S_INS_NEW,
    S_RAISE_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    AS_POS,
    AS_J,
    AS_JM1
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_MOVE,
    WD_NEW,
    WD_RAISE
  } wdata_sel_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [HND_W-1:0] handle;
    logic [REF_W-1:0] refs;
  } entry_t;

  typedef struct packed {
    logic       load_item;
    logic       pos_clr;
    logic       pos_inc;
    logic       j_from_cnt;
    logic       j_from_pos;
    logic       j_dec;
    logic       j_inc;
    logic       ram_re;
    logic       ram_we;
    addr_sel_e  addr_sel;
    wdata_sel_e wd_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       stat_set;
    status_e    stat_val;
    logic       res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    func_e func;
    logic  scan_end;
    logic  key_lt;
    logic  key_eq;
    logic  full;
    logic  j_gt_pos;
    logic  j_lt_cnt;
    logic  rsp_busy;
  } ctrl_stat_t;

  function automatic logic [REF_W-1:0] ref_sat_inc(input logic [REF_W-1:0] r);
    ref_sat_inc = (r == {REF_W{1'b1}}) ? r : r + REF_W'(1);
  endfunction

endpackage

// File: rtl/core/srkt_req_if.sv
// ----------------------------------------------------------------------------
// srkt_req_if: request channel
// Valid/ready channel that carries one table operation per transaction.
// ----------------------------------------------------------------------------
interface srkt_req_if;
  logic                       valid;
  logic                       ready;
  logic [srkt_pkg::FUNC_W-1:0] func;
  logic [srkt_pkg::KEY_W-1:0]  key;
  logic [srkt_pkg::HND_W-1:0]  handle_in;

  modport source (output valid, output func, output key, output handle_in, input ready);
  modport sink   (input valid, input func, input key, input handle_in, output ready);
endinterface

// File: rtl/core/srkt_rsp_if.sv
// ----------------------------------------------------------------------------
// srkt_rsp_if: response channel
// Valid/ready channel that carries one operation result per transaction.
// ----------------------------------------------------------------------------
interface srkt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [srkt_pkg::STAT_W-1:0] status;
  logic [srkt_pkg::HND_W-1:0]  handle_out;
  logic [srkt_pkg::REF_W-1:0]  ref_count;
  logic [srkt_pkg::USED_W-1:0] entries_used;

  modport source (output valid, output status, output handle_out, output ref_count,
                  output entries_used, input ready);
  modport sink   (input valid, input status, input handle_out, input ref_count,
                  input entries_used, output ready);
endinterface

// File: rtl/core/srkt_ram.sv
// ----------------------------------------------------------------------------
// srkt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/srkt_ctrl.sv
// ----------------------------------------------------------------------------
// srkt_ctrl: operation sequencer
// Walks the scan, shift and result steps of each operation and issues
// datapath commands from the datapath status flags.
// ----------------------------------------------------------------------------
module srkt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  srkt_pkg::ctrl_stat_t stat_i,
  output srkt_pkg::ctrl_cmd_t  cmd_o
);

  srkt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srkt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srkt_pkg::S_IDLE: begin
        if (req_valid_i) state_d = srkt_pkg::S_SCAN_RD;
      end
      srkt_pkg::S_SCAN_RD: begin
        if (stat_i.func == srkt_pkg::FN_NONE) begin
          state_d = srkt_pkg::S_FINISH;
        end else if (stat_i.scan_end) begin
          if (stat_i.func == srkt_pkg::FN_INSERT && !stat_i.full) state_d = srkt_pkg::S_INS_RD;
          else state_d = srkt_pkg::S_FINISH;
        end else begin
          state_d = srkt_pkg::S_SCAN_CHK;
        end
      end
      srkt_pkg::S_SCAN_CHK: begin
        priority if (stat_i.key_lt) begin
          state_d = srkt_pkg::S_SCAN_RD;
        end else if (stat_i.key_eq) begin
          unique case (stat_i.func)
            srkt_pkg::FN_INSERT: state_d = srkt_pkg::S_RAISE_WR;
            srkt_pkg::FN_REMOVE: state_d = srkt_pkg::S_DEL_RD;
            default:             state_d = srkt_pkg::S_FINISH;
          endcase
        end else begin
          if (stat_i.func == srkt_pkg::FN_INSERT && !stat_i.full) state_d = srkt_pkg::S_INS_RD;
          else state_d = srkt_pkg::S_FINISH;
        end
      end
      srkt_pkg::S_INS_RD: begin
        state_d = stat_i.j_gt_pos ? srkt_pkg::S_INS_WR : srkt_pkg::S_INS_NEW;
      end
      srkt_pkg::S_INS_WR:   state_d = srkt_pkg::S_INS_RD;
      srkt_pkg::S_INS_NEW:  state_d = srkt_pkg::S_FINISH;
      srkt_pkg::S_RAISE_WR: state_d = srkt_pkg::S_FINISH;
      srkt_pkg::S_DEL_RD: begin
        state_d = stat_i.j_lt_cnt ? srkt_pkg::S_DEL_WR : srkt_pkg::S_FINISH;
      end
      srkt_pkg::S_DEL_WR:   state_d = srkt_pkg::S_DEL_RD;
      srkt_pkg::S_FINISH: begin
        if (!stat_i.rsp_busy) state_d = srkt_pkg::S_IDLE;
      end
      default: state_d = srkt_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = srkt_pkg::AS_POS;
    cmd_o.wd_sel   = srkt_pkg::WD_MOVE;
    cmd_o.stat_val = srkt_pkg::ST_NOT_FOUND;
    req_ready_o    = 1'b0;
    unique case (state_q)
      srkt_pkg::S_IDLE: begin
        req_ready_o     = 1'b1;
        cmd_o.load_item = req_valid_i;
        cmd_o.pos_clr   = req_valid_i;
      end
      srkt_pkg::S_SCAN_RD: begin
        if (stat_i.func == srkt_pkg::FN_NONE) begin
          cmd_o.stat_set = 1'b1;
        end else if (stat_i.scan_end) begin
          if (stat_i.func == srkt_pkg::FN_INSERT) begin
            if (stat_i.full) begin
              cmd_o.stat_set = 1'b1;
              cmd_o.stat_val = srkt_pkg::ST_FULL;
            end else begin
              cmd_o.j_from_cnt = 1'b1;
            end
          end else begin
            cmd_o.stat_set = 1'b1;
          end
        end else begin
          cmd_o.ram_re   = 1'b1;
          cmd_o.addr_sel = srkt_pkg::AS_POS;
        end
      end
      srkt_pkg::S_SCAN_CHK: begin
        priority if (stat_i.key_lt) begin
          cmd_o.pos_inc = 1'b1;
        end else if (stat_i.key_eq) begin
          unique case (stat_i.func)
            srkt_pkg::FN_INSERT: ;
            srkt_pkg::FN_REMOVE: cmd_o.j_from_pos = 1'b1;
            default: begin
              cmd_o.stat_set = 1'b1;
              cmd_o.stat_val = srkt_pkg::ST_FOUND;
            end
          endcase
        end else begin
          if (stat_i.func == srkt_pkg::FN_INSERT) begin
            if (stat_i.full) begin
              cmd_o.stat_set = 1'b1;
              cmd_o.stat_val = srkt_pkg::ST_FULL;
            end else begin
              cmd_o.j_from_cnt = 1'b1;
            end
          end else begin
            cmd_o.stat_set = 1'b1;
          end
        end
      end
      srkt_pkg::S_INS_RD: begin
        if (stat_i.j_gt_pos) begin
          cmd_o.ram_re   = 1'b1;
          cmd_o.addr_sel = srkt_pkg::AS_JM1;
        end
      end
      srkt_pkg::S_INS_WR: begin
        cmd_o.ram_we   = 1'b1;
        cmd_o.addr_sel = srkt_pkg::AS_J;
        cmd_o.wd_sel   = srkt_pkg::WD_MOVE;
        cmd_o.j_dec    = 1'b1;
      end
      srkt_pkg::S_INS_NEW: begin
        cmd_o.ram_we   = 1'b1;
        cmd_o.addr_sel = srkt_pkg::AS_POS;
        cmd_o.wd_sel   = srkt_pkg::WD_NEW;
        cmd_o.cnt_inc  = 1'b1;
        cmd_o.stat_set = 1'b1;
        cmd_o.stat_val = srkt_pkg::ST_INSERTED;
      end
      srkt_pkg::S_RAISE_WR: begin
        cmd_o.ram_we   = 1'b1;
        cmd_o.addr_sel = srkt_pkg::AS_POS;
        cmd_o.wd_sel   = srkt_pkg::WD_RAISE;
        cmd_o.stat_set = 1'b1;
        cmd_o.stat_val = srkt_pkg::ST_RAISED;
      end
      srkt_pkg::S_DEL_RD: begin
        if (stat_i.j_lt_cnt) begin
          cmd_o.ram_re   = 1'b1;
          cmd_o.addr_sel = srkt_pkg::AS_J;
        end else begin
          cmd_o.cnt_dec  = 1'b1;
          cmd_o.stat_set = 1'b1;
          cmd_o.stat_val = srkt_pkg::ST_REMOVED;
        end
      end
      srkt_pkg::S_DEL_WR: begin
        cmd_o.ram_we   = 1'b1;
        cmd_o.addr_sel = srkt_pkg::AS_JM1;
        cmd_o.wd_sel   = srkt_pkg::WD_MOVE;
        cmd_o.j_inc    = 1'b1;
      end
      srkt_pkg::S_FINISH: begin
        cmd_o.res_load = !stat_i.rsp_busy;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/srkt_dp.sv
// ----------------------------------------------------------------------------
// srkt_dp: table datapath
// Entry memory, scan and shift pointers, entry count and the response
// register, all driven by controller commands.
// ----------------------------------------------------------------------------
module srkt_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  srkt_pkg::ctrl_cmd_t          cmd_i,
  output srkt_pkg::ctrl_stat_t         stat_o,
  input  logic [srkt_pkg::FUNC_W-1:0]  func_i,
  input  logic [srkt_pkg::KEY_W-1:0]   key_i,
  input  logic [srkt_pkg::HND_W-1:0]   handle_in_i,
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output logic [srkt_pkg::STAT_W-1:0]  status_o,
  output logic [srkt_pkg::HND_W-1:0]   handle_out_o,
  output logic [srkt_pkg::REF_W-1:0]   ref_count_o,
  output logic [srkt_pkg::USED_W-1:0]  entries_used_o
);

  srkt_pkg::func_e                func_q;
  logic [srkt_pkg::KEY_W-1:0]     key_q;
  logic [srkt_pkg::HND_W-1:0]     handle_q;
  logic [srkt_pkg::CNT_W-1:0]     count_q, count_d;
  logic [srkt_pkg::CNT_W-1:0]     pos_q, pos_d;
  logic [srkt_pkg::CNT_W-1:0]     j_q, j_d;
  logic [srkt_pkg::CNT_W-1:0]     jm1;
  srkt_pkg::status_e              status_q;
  logic                           rsp_valid_q;
  logic [srkt_pkg::STAT_W-1:0]    res_status_q;
  logic [srkt_pkg::HND_W-1:0]     res_handle_q;
  logic [srkt_pkg::REF_W-1:0]     res_ref_q;
  logic [srkt_pkg::USED_W-1:0]    res_used_q;

  logic [srkt_pkg::CNT_W-1:0]     addr_full;
  logic [srkt_pkg::IDX_W-1:0]     ram_addr;
  srkt_pkg::entry_t               wdata;
  srkt_pkg::entry_t               rd;
  logic [srkt_pkg::ENTRY_W-1:0]   rdata;
  logic [srkt_pkg::REF_W-1:0]     res_ref_d;

  assign jm1 = j_q - srkt_pkg::CNT_W'(1);
  assign rd  = srkt_pkg::entry_t'(rdata);

  always_comb begin
    unique case (cmd_i.addr_sel)
      srkt_pkg::AS_POS: addr_full = pos_q;
      srkt_pkg::AS_J:   addr_full = j_q;
      srkt_pkg::AS_JM1: addr_full = jm1;
      default:          addr_full = pos_q;
    endcase
  end
  assign ram_addr = addr_full[srkt_pkg::IDX_W-1:0];

  always_comb begin
    unique case (cmd_i.wd_sel)
      srkt_pkg::WD_MOVE:  wdata = rd;
      srkt_pkg::WD_NEW:   wdata = '{key: key_q, handle: handle_q,
                                    refs: srkt_pkg::REF_W'(1)};
      srkt_pkg::WD_RAISE: wdata = '{key: rd.key, handle: rd.handle,
                                    refs: srkt_pkg::ref_sat_inc(rd.refs)};
      default:            wdata = rd;
    endcase
  end

  srkt_ram #(
    .WIDTH(srkt_pkg::ENTRY_W),
    .DEPTH(srkt_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (ram_addr),
    .wdata_i (wdata),
    .re_i    (cmd_i.ram_re),
    .raddr_i (ram_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.pos_clr) pos_d = '0;
    else if (cmd_i.pos_inc) pos_d = pos_q + srkt_pkg::CNT_W'(1);
  end

  always_comb begin
    j_d = j_q;
    priority if (cmd_i.j_from_cnt) j_d = count_q;
    else if (cmd_i.j_from_pos) j_d = pos_q + srkt_pkg::CNT_W'(1);
    else if (cmd_i.j_dec) j_d = jm1;
    else if (cmd_i.j_inc) j_d = j_q + srkt_pkg::CNT_W'(1);
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) count_d = count_q + srkt_pkg::CNT_W'(1);
    else if (cmd_i.cnt_dec) count_d = count_q - srkt_pkg::CNT_W'(1);
  end

  always_comb begin
    unique case (status_q)
      srkt_pkg::ST_INSERTED: res_ref_d = srkt_pkg::REF_W'(1);
      srkt_pkg::ST_RAISED:   res_ref_d = srkt_pkg::ref_sat_inc(rd.refs);
      srkt_pkg::ST_FOUND:    res_ref_d = rd.refs;
      default:               res_ref_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.res_load) rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    j_q   <= j_d;
    if (cmd_i.load_item) begin
      func_q   <= srkt_pkg::func_e'(func_i);
      key_q    <= key_i;
      handle_q <= handle_in_i;
    end
    if (cmd_i.stat_set) status_q <= cmd_i.stat_val;
    if (cmd_i.res_load) begin
      res_status_q <= status_q;
      res_handle_q <= (status_q == srkt_pkg::ST_FOUND) ? rd.handle : '0;
      res_ref_q    <= res_ref_d;
      res_used_q   <= srkt_pkg::USED_W'(count_q);
    end
  end

  assign stat_o.func     = func_q;
  assign stat_o.scan_end = (pos_q == count_q);
  assign stat_o.key_lt   = (rd.key < key_q);
  assign stat_o.key_eq   = (rd.key == key_q);
  assign stat_o.full     = (count_q == srkt_pkg::CNT_W'(srkt_pkg::TABLE_DEPTH));
  assign stat_o.j_gt_pos = (j_q > pos_q);
  assign stat_o.j_lt_cnt = (j_q < count_q);
  assign stat_o.rsp_busy = rsp_valid_q & ~rsp_ready_i;

  assign rsp_valid_o    = rsp_valid_q;
  assign status_o       = res_status_q;
  assign handle_out_o   = res_handle_q;
  assign ref_count_o    = res_ref_q;
  assign entries_used_o = res_used_q;

endmodule

// File: rtl/core/sorted_refcount_key_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_refcount_key_table_unit: sorted key table with reference counts
// Table of up to 256 entries kept in ascending key order, each with a data
// handle and a reference count; insert, remove and lookup by key.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one operation per transaction (func, key, handle_in);
//   rsp_o returns exactly one result per operation, in order.
//   Entries live in a single-port-read RAM; the scan reads an entry, then
//   checks its key, and each shift move is a read, then a write.
//   One operation is in flight at a time; req_i.ready is high only between
//   operations. The response sits in an output register, so a new request
//   is taken while the previous response still waits; an operation that
//   finishes while rsp_o is stalled holds until the register frees up.
//   Reset clears the entry count and the response valid; the RAM is not
//   cleared, no entry at or beyond the count is ever read.
// ----------------------------------------------------------------------------
module sorted_refcount_key_table_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  srkt_req_if.sink   req_i,
  srkt_rsp_if.source rsp_o
);

  srkt_pkg::ctrl_cmd_t  cmd;
  srkt_pkg::ctrl_stat_t stat;

  srkt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  srkt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .func_i         (req_i.func),
    .key_i          (req_i.key),
    .handle_in_i    (req_i.handle_in),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .status_o       (rsp_o.status),
    .handle_out_o   (rsp_o.handle_out),
    .ref_count_o    (rsp_o.ref_count),
    .entries_used_o (rsp_o.entries_used)
  );

endmodule

// File: rtl/core/srkt_checker.sv
// ----------------------------------------------------------------------------
// srkt_checker: port-level checks for the sorted key table
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module srkt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [srkt_pkg::STAT_W-1:0] status_i,
  input logic [srkt_pkg::HND_W-1:0]  handle_out_i,
  input logic [srkt_pkg::REF_W-1:0]  ref_count_i,
  input logic [srkt_pkg::USED_W-1:0] entries_used_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i)
      && $stable(handle_out_i) && $stable(ref_count_i) && $stable(entries_used_i))
    else $error("response changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while an operation is in flight");

  a_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != srkt_pkg::ST_FOUND |-> handle_out_i == '0)
    else $error("handle returned without a hit");

  a_insert_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == srkt_pkg::ST_INSERTED |-> ref_count_i == 16'd1
      && entries_used_i != '0)
    else $error("new entry reported with wrong count");

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> entries_used_i <= srkt_pkg::USED_W'(srkt_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

endmodule

bind sorted_refcount_key_table_unit srkt_checker u_srkt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .handle_out_i   (rsp_o.handle_out),
  .ref_count_i    (rsp_o.ref_count),
  .entries_used_i (rsp_o.entries_used)
);

// File: tb/srkt_table_checker.sv
// ----------------------------------------------------------------------------
// srkt_table_checker: scoreboard for the sorted reference-counted key table
// Watches the request and response channels and keeps its own copy of the
// sorted table. Each accepted request queues the result it should produce.
// Each accepted response is compared field by field with the oldest queued
// result.
// ----------------------------------------------------------------------------
module srkt_table_checker
  import srkt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  srkt_req_if  req_i,
  srkt_rsp_if  rsp_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   peak_used_o,
  output int   full_hits_o,
  output int   sat_hits_o
);

  typedef struct packed {
    status_e           status;
    logic [HND_W-1:0]  handle;
    logic [REF_W-1:0]  refs;
    logic [USED_W-1:0] used;
  } table_result_t;

  logic [KEY_W-1:0] tbl_key [TABLE_DEPTH];
  logic [HND_W-1:0] tbl_hnd [TABLE_DEPTH];
  logic [REF_W-1:0] tbl_ref [TABLE_DEPTH];
  int               tbl_used;
  table_result_t    result_q [$];

  function automatic table_result_t table_apply(func_e fn, logic [KEY_W-1:0] k,
                                                logic [HND_W-1:0] h);
    table_result_t r;
    int            pos;
    logic          hit;
    r.status = ST_NOT_FOUND;
    r.handle = '0;
    r.refs   = '0;
    for (pos = 0; pos < tbl_used; pos++) begin
      if (tbl_key[pos] >= k) break;
    end
    hit = (pos < tbl_used) && (tbl_key[pos] == k);
    case (fn)
      FN_INSERT: begin
        if (hit) begin
          if (tbl_ref[pos] == {REF_W{1'b1}}) begin
            sat_hits_o++;
          end else begin
            tbl_ref[pos] = tbl_ref[pos] + 1'b1;
          end
          r.status = ST_RAISED;
          r.refs   = tbl_ref[pos];
        end else if (tbl_used >= TABLE_DEPTH) begin
          r.status = ST_FULL;
          full_hits_o++;
        end else begin
          for (int j = tbl_used; j > pos; j--) begin
            tbl_key[j] = tbl_key[j-1];
            tbl_hnd[j] = tbl_hnd[j-1];
            tbl_ref[j] = tbl_ref[j-1];
          end
          tbl_key[pos] = k;
          tbl_hnd[pos] = h;
          tbl_ref[pos] = REF_W'(1);
          tbl_used++;
          r.status = ST_INSERTED;
          r.refs   = REF_W'(1);
        end
      end
      FN_REMOVE: begin
        if (hit) begin
          for (int j = pos + 1; j < tbl_used; j++) begin
            tbl_key[j-1] = tbl_key[j];
            tbl_hnd[j-1] = tbl_hnd[j];
            tbl_ref[j-1] = tbl_ref[j];
          end
          tbl_used--;
          r.status = ST_REMOVED;
        end
      end
      FN_LOOKUP: begin
        if (hit) begin
          r.status = ST_FOUND;
          r.handle = tbl_hnd[pos];
          r.refs   = tbl_ref[pos];
        end
      end
      default: ;
    endcase
    r.used = USED_W'(tbl_used);
    return r;
  endfunction

  task automatic check_result();
    table_result_t want;
    if (result_q.size() == 0) begin
      $error("response with no pending transaction: status %0d", rsp_i.status);
      fail_count_o++;
      return;
    end
    want = result_q.pop_front();
    if (rsp_i.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, rsp_i.status);
      fail_count_o++;
    end
    if (rsp_i.handle_out !== want.handle) begin
      $error("handle_out: expected %h, actual %h", want.handle, rsp_i.handle_out);
      fail_count_o++;
    end
    if (rsp_i.ref_count !== want.refs) begin
      $error("ref_count: expected %0d, actual %0d", want.refs, rsp_i.ref_count);
      fail_count_o++;
    end
    if (rsp_i.entries_used !== want.used) begin
      $error("entries_used: expected %0d, actual %0d", want.used, rsp_i.entries_used);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tbl_used = 0;
      result_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      peak_used_o  = 0;
      full_hits_o  = 0;
      sat_hits_o   = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        check_result();
      end
      if (req_i.valid && req_i.ready) begin
        result_q.push_back(table_apply(func_e'(req_i.func), req_i.key, req_i.handle_in));
        if (tbl_used > peak_used_o) peak_used_o = tbl_used;
      end
      pending_o = result_q.size();
    end
  end

endmodule

// File: tb/sorted_refcount_key_table_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_refcount_key_table_unit_tb: regression for the sorted key table
// Drives insert, remove, lookup and unused operations: a directed pass over
// field extremes, repeated inserts of one key, random traffic over a
// small key pool, a fill to a full table with traffic while full, and a
// drain. Both channels idle at random; the checker judges every response.
// ----------------------------------------------------------------------------
module sorted_refcount_key_table_unit_tb;
  import srkt_pkg::*;

  localparam int POOL_KEYS   = 48;
  localparam int SAT_INSERTS = 20;
  localparam int RAND_OPS    = 450;
  localparam int FILL_KEYS   = 300;
  localparam int FULL_OPS    = 60;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_WAIT  = 600;
  localparam int MAX_LAT     = 2 * TABLE_DEPTH + 8;
  localparam int MAX_GAP     = 60;
  localparam int MAX_STALL   = 80;
  localparam int TOTAL_OPS   = 20 + SAT_INSERTS + 2 + RAND_OPS + 2 * FILL_KEYS + 3 + FULL_OPS;
  localparam int CYCLE_LIMIT = 4 * TOTAL_OPS * (MAX_LAT + MAX_GAP + MAX_STALL)
                               + 4 * HOLD_CYCLES;

  logic clk_i;
  logic rst_ni;

  srkt_req_if req_if ();
  srkt_rsp_if rsp_if ();

  int   fail_count;
  int   pending;
  int   peak_used;
  int   full_hits;
  int   sat_hits;
  int   ops_sent;
  int   cycles;
  logic calm;
  logic hold_req;
  logic [KEY_W-1:0] key_pool [POOL_KEYS];

  sorted_refcount_key_table_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  srkt_table_checker u_table_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .peak_used_o  (peak_used),
    .full_hits_o  (full_hits),
    .sat_hits_o   (sat_hits)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, MAX_GAP);
  endfunction

  function automatic logic [HND_W-1:0] pick_handle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return HND_W'($urandom);
  endfunction

  function automatic logic [KEY_W-1:0] fill_key(int i);
    return KEY_W'(i * 211 + 7);
  endfunction

  // one request transaction; returns at the falling edge after acceptance
  task automatic send_op(func_e fn, logic [KEY_W-1:0] k, logic [HND_W-1:0] h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid     = 1'b1;
    req_if.func      = fn;
    req_if.key       = k;
    req_if.handle_in = h;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    ops_sent++;
  endtask

  // response side: random stalls, long stalls, and a long hold on request
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req     = 1'b0;
        rsp_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (calm) begin
        rsp_if.ready = 1'b1;
      end else if ($urandom_range(0, 99) == 0) begin
        rsp_if.ready = 1'b0;
        repeat ($urandom_range(20, MAX_STALL)) @(negedge clk_i);
      end else begin
        rsp_if.ready = ($urandom_range(0, 99) < 75);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("sorted_refcount_key_table_unit regression: fail");
    $finish;
  end

  initial begin
    int r;
    func_e fn;
    logic [KEY_W-1:0] k;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.func      = FN_INSERT;
    req_if.key       = '0;
    req_if.handle_in = '0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    ops_sent         = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 16'h8000;
    key_pool[3] = 16'h7FFF;
    for (int i = 4; i < POOL_KEYS; i++) key_pool[i] = KEY_W'($urandom);

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty table, field extremes, duplicates, unused code
    send_op(FN_LOOKUP, 16'hFFFF, '0);
    send_op(FN_REMOVE, 16'h0000, '1);
    send_op(FN_NONE,   16'hFFFF, '1);
    send_op(FN_INSERT, 16'h8000, 32'hFFFF_FFFF);
    send_op(FN_INSERT, 16'h0000, 32'h0000_0000);
    send_op(FN_INSERT, 16'hFFFF, 32'hA5A5_5A5A);
    send_op(FN_INSERT, 16'h8000, 32'h0000_1234);
    send_op(FN_LOOKUP, 16'h8000, '0);
    send_op(FN_LOOKUP, 16'h0000, '1);
    send_op(FN_LOOKUP, 16'hFFFF, '0);
    send_op(FN_LOOKUP, 16'h7FFF, '0);
    send_op(FN_NONE,   16'h0000, '0);
    send_op(FN_REMOVE, 16'h8000, '0);
    send_op(FN_LOOKUP, 16'h8000, '0);
    send_op(FN_REMOVE, 16'hFFFF, '0);
    send_op(FN_REMOVE, 16'h0000, '0);
    send_op(FN_REMOVE, 16'h0000, '0);

    // repeated inserts of one key raise its count
    calm = 1'b1;
    for (int i = 0; i < SAT_INSERTS; i++) send_op(FN_INSERT, 16'h4242, pick_handle());
    calm = 1'b0;
    send_op(FN_LOOKUP, 16'h4242, '0);
    send_op(FN_REMOVE, 16'h4242, '0);

    // random traffic over a small key pool
    for (int n = 0; n < RAND_OPS; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == 100 || n == 320) hold_req = 1'b1;
      r  = $urandom_range(0, 99);
      fn = func_e'((r < 40) ? FN_INSERT : (r < 65) ? FN_REMOVE :
                   (r < 95) ? FN_LOOKUP : FN_NONE);
      k  = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_KEYS - 1)]
                                        : KEY_W'($urandom);
      send_op(fn, k, pick_handle());
    end

    // fill to full, then present and new keys while full
    calm = 1'b0;
    for (int i = 0; i < FILL_KEYS; i++) send_op(FN_INSERT, fill_key(i), pick_handle());
    send_op(FN_INSERT, fill_key(0), '0);
    send_op(FN_INSERT, 16'h0001, '1);
    send_op(FN_INSERT, 16'hFFFF, '0);
    for (int n = 0; n < FULL_OPS; n++) begin
      r  = $urandom_range(0, 99);
      fn = func_e'((r < 40) ? FN_INSERT : (r < 60) ? FN_REMOVE : FN_LOOKUP);
      k  = ($urandom_range(0, 1) == 0) ? fill_key($urandom_range(0, FILL_KEYS - 1))
                                       : KEY_W'($urandom);
      send_op(fn, k, pick_handle());
    end

    // drain with shifts across a large table
    for (int i = 0; i < FILL_KEYS; i++) send_op(FN_REMOVE, fill_key(i), '0);

    req_if.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d transactions: %0d saturated count raises, %0d full refusals",
             ops_sent, sat_hits, full_hits);
    $display("peak table occupancy %0d of %0d entries", peak_used, TABLE_DEPTH);
    if (fail_count == 0) begin
      $display("sorted_refcount_key_table_unit regression: pass");
    end else begin
      $display("sorted_refcount_key_table_unit regression: fail");
    end
    $finish;
  end

endmodule
